>>> rtl/core/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
`timescale 1ns / 1ps
package rgbhsv_pkg;

  localparam int unsigned DivW     = 8;   // divisor width (delta, max)
  localparam int unsigned HueShift = 26;  // hue numerator t*2^15 stays below 2^26
  localparam int unsigned SatShift = 24;  // saturation numerator 65535*delta stays below 2^24
  localparam int unsigned HueRecW  = 25;  // width of ceil(2^HueShift / (3*d))
  localparam int unsigned SatRecW  = 25;  // width of ceil(2^SatShift / d)
  localparam int unsigned HueW     = 16;
  localparam int unsigned SatW     = 16;
  localparam int unsigned ChanW    = 8;

  typedef enum logic [1:0] {
    SecRed   = 2'd0,
    SecGreen = 2'd1,
    SecBlue  = 2'd2
  } sector_e;

  // Classified item passed from front to back.
  typedef struct packed {
    logic [10:0]      t;      // base*delta + num, in [0, 6*delta)
    logic [DivW-1:0]  delta;
    logic [ChanW-1:0] mx;
  } cls_t;

endpackage

>>> rtl/core/rgbhsv_front.sv
// Front part: extracts channels, finds max/min and sector, builds the hue numerator.
`timescale 1ns / 1ps
module rgbhsv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,
  output logic              cls_valid_o,
  input  logic              cls_ready_i,
  output rgbhsv_pkg::cls_t  cls_o
);
  import rgbhsv_pkg::*;

  logic [7:0] r, g, b, mx, mn, dl;
  sector_e    sec;
  logic [10:0] t;
  cls_t       cls_d, cls_q;
  logic       vld_q;

  assign r = s_axis_tdata[23:16];
  assign g = s_axis_tdata[15:8];
  assign b = s_axis_tdata[7:0];

  always_comb begin
    if (r >= g && r >= b) begin
      sec = SecRed;  mx = r;
    end else if (g >= b) begin
      sec = SecGreen; mx = g;
    end else begin
      sec = SecBlue; mx = b;
    end
    mn = (r <= g) ? r : g;
    if (b < mn) mn = b;
    dl = mx - mn;
    unique case (sec)
      SecRed:   t = (g >= b) ? 11'({3'b0, g} - {3'b0, b})
                             : 11'(11'(6) * {3'b0, dl} + {3'b0, g} - {3'b0, b});
      SecGreen: t = 11'({2'b0, dl, 1'b0} + {3'b0, b} - {3'b0, r});
      SecBlue:  t = 11'({1'b0, dl, 2'b0} + {3'b0, r} - {3'b0, g});
      default:  t = '0;
    endcase
    cls_d = '{t: t, delta: dl, mx: mx};
  end

  assign s_axis_tready = !vld_q || cls_ready_i;
  assign cls_valid_o   = vld_q;
  assign cls_o         = cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (s_axis_tready) vld_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) cls_q <= cls_d;
  end
endmodule

>>> rtl/core/rgbhsv_fifo.sv
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module rgbhsv_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rgbhsv_pkg::cls_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rgbhsv_pkg::cls_t  out_data_o
);
  import rgbhsv_pkg::*;

  cls_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = mem_q[rp_q];
  assign wr = in_valid_i && in_ready_o;
  assign rd = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= 2'(cnt_q + {1'b0, wr} - {1'b0, rd});
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_data_i;
  end
endmodule

>>> rtl/core/rgbhsv_back.sv
// Back part: reciprocal multiply pipeline for hue and saturation, output register.
`timescale 1ns / 1ps
module rgbhsv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cls_valid_i,
  output logic              cls_ready_o,
  input  rgbhsv_pkg::cls_t  cls_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata
);
  import rgbhsv_pkg::*;

  localparam int unsigned HpW = HueShift + HueRecW;
  localparam int unsigned SpW = SatShift + SatRecW;

  // constant reciprocal tables, entry 0 unused
  logic [HueRecW-1:0]  hue_rec [2**DivW];
  logic [SatRecW-1:0]  sat_rec [2**DivW];

  logic                v1_q, v2_q, v3_q;
  logic [HueRecW-1:0]  rh_q;
  logic [SatRecW-1:0]  rs_q;
  logic [HueShift-1:0] hn1_q, hn2_q;  // t*32768, hue = floor(hn / (3*delta))
  logic [SatShift-1:0] sn1_q, sn2_q;  // 65535*delta
  logic [DivW-1:0]     dl1_q, dl2_q;
  logic [ChanW-1:0]    mx1_q, mx2_q, mx3_q;
  logic [HueW:0]       hq_d, hq_q, hc;
  logic [SatW:0]       sq_d, sq_q, sc;
  logic [HpW-1:0]      hp;
  logic [SpW-1:0]      sp;
  logic [HueShift:0]   hchk;
  logic [SatShift:0]   schk;
  logic [HueW-1:0]     hue_q;
  logic [SatW-1:0]     sat_q;
  logic                adv;

  for (genvar i = 0; i < 2**DivW; i++) begin : g_rec
    localparam int unsigned HueDiv = (i == 0) ? 1 : 3 * i;
    localparam int unsigned SatDiv = (i == 0) ? 1 : i;
    localparam logic [HueRecW-1:0] HueRec =
      HueRecW'(((1 << HueShift) + HueDiv - 1) / HueDiv);
    localparam logic [SatRecW-1:0] SatRec =
      SatRecW'(((1 << SatShift) + SatDiv - 1) / SatDiv);
    assign hue_rec[i] = HueRec;
    assign sat_rec[i] = SatRec;
  end

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign cls_ready_o   = adv;
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {mx3_q, sat_q, hue_q};

  // quotient estimate is exact or one too high since numerators stay below 2^shift
  always_comb begin
    hp   = HpW'(hn1_q) * HpW'(rh_q);
    sp   = SpW'(sn1_q) * SpW'(rs_q);
    hq_d = hp[HueShift +: HueW+1];
    sq_d = sp[SatShift +: SatW+1];
    hchk = (HueShift+1)'(hq_q) * (HueShift+1)'({2'b0, dl2_q} + {1'b0, dl2_q, 1'b0});
    schk = (SatShift+1)'(sq_q) * (SatShift+1)'(mx2_q);
    hc   = (hchk > {1'b0, hn2_q}) ? hq_q - 1'b1 : hq_q;
    sc   = (schk > {1'b0, sn2_q}) ? sq_q - 1'b1 : sq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= cls_valid_i; v2_q <= v1_q; v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rh_q  <= hue_rec[cls_i.delta];
      rs_q  <= sat_rec[cls_i.mx];
      hn1_q <= {cls_i.t, 15'b0};
      sn1_q <= {cls_i.delta, 16'b0} - {16'b0, cls_i.delta};
      dl1_q <= cls_i.delta;
      mx1_q <= cls_i.mx;
      hq_q  <= hq_d;
      sq_q  <= sq_d;
      hn2_q <= hn1_q;
      sn2_q <= sn1_q;
      dl2_q <= dl1_q;
      mx2_q <= mx1_q;
      hue_q <= (dl2_q == '0) ? '0 : hc[HueW-1:0];
      sat_q <= (mx2_q == '0) ? '0 : sc[SatW-1:0];
      mx3_q <= mx2_q;
    end
  end
endmodule

>>> rtl/core/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter.
// Throughput: one item per cycle while the output is not stalled, set by the pipelined
// reciprocal multiply in the back part.
// A two-entry queue decouples classification from arithmetic.
// Reset (rst_ni low, asynchronous) empties all stages; payload registers are not reset.
`timescale 1ns / 1ps
module rgb_to_hsv_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // hue[15:0], saturation[31:16], brightness[39:32]
);
  import rgbhsv_pkg::*;

  cls_t f_data, q_data;
  logic f_valid, f_ready, q_valid, q_ready;

  rgbhsv_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .cls_valid_o(f_valid), .cls_ready_i(f_ready), .cls_o(f_data)
  );

  rgbhsv_fifo u_fifo (
    .clk_i, .rst_ni, .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_data),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_data)
  );

  rgbhsv_back u_back (
    .clk_i, .rst_ni, .cls_valid_i(q_valid), .cls_ready_o(q_ready), .cls_i(q_data),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );
endmodule

>>> rtl/core/rgbhsv_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
`timescale 1ns / 1ps
module rgbhsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[31:16] == 16'd0 |-> m_axis_tdata[15:0] == 16'd0)
    else $error("grey pixel with nonzero hue");
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[39:32] == 8'd0 |-> m_axis_tdata[31:16] == 16'd0)
    else $error("black pixel with nonzero saturation");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid after reset");
endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

>>> sim/rgb_to_hsv_converter_tb.sv
// Testbench for the RGB to HSV converter: directed and random pixels, checked against a predictor.
`timescale 1ns / 1ps
module rgb_to_hsv_converter_tb;

  typedef struct packed {
    logic [7:0]  brightness;
    logic [15:0] saturation;
    logic [15:0] hue;
  } hsv_t;

  localparam int unsigned IdleLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // pixel[31:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // hue[15:0], saturation[31:16], brightness[39:32]

  logic [31:0] pixel_q[$];
  hsv_t        hsv_q[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          stim_done = 1'b0;

  rgb_to_hsv_converter dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic hsv_t convert_pixel(input logic [31:0] px);
    int    r, g, b, mx, mn, d, t;
    hsv_t  res;
    r = int'(px[23:16]);
    g = int'(px[15:8]);
    b = int'(px[7:0]);
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    res = '0;
    res.brightness = mx[7:0];
    if (d != 0) begin
      // ties go to red, then green
      if (mx == r) begin
        t = g - b;
        if (t < 0) t += 6 * d;
      end else if (mx == g) begin
        t = 2 * d + b - r;
      end else begin
        t = 4 * d + r - g;
      end
      res.hue = 16'((longint'(65536) * t) / (6 * d));
    end
    if (mx != 0) res.saturation = 16'((65535 * d) / mx);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid) hsv_q.push_back(convert_pixel(s_axis_tdata));
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pixel_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    hsv_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (hsv_q.size() == 0) begin
        report_mismatch("unexpected item", 32'(got.hue), 32'd0);
      end else begin
        want = hsv_q.pop_front();
        if (got.hue != want.hue) report_mismatch("hue", 32'(got.hue), 32'(want.hue));
        if (got.saturation != want.saturation)
          report_mismatch("saturation", 32'(got.saturation), 32'(want.saturation));
        if (got.brightness != want.brightness)
          report_mismatch("brightness", 32'(got.brightness), 32'(want.brightness));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_pixel();
    logic [7:0] r, g, b;
    logic [31:0] px;
    px = $urandom;
    case ($urandom_range(5))
      0: begin  // near-grey, small delta
        r = 8'($urandom); g = r ^ 8'($urandom_range(3)); b = r ^ 8'($urandom_range(3));
        px[23:0] = {r, g, b};
      end
      1: begin  // forced ties
        r = 8'($urandom); b = 8'($urandom);
        px[23:0] = ($urandom_range(1)) ? {r, r, b} : {r, b, r};
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic run_phase(input int unsigned n, input int unsigned idle, input int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) pixel_q.push_back(rand_pixel());
    wait (pixel_q.size() == 0 && !s_axis_tvalid);
  endtask

  initial begin
    logic [31:0] directed[];
    directed = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'hAA80_8080, 32'h00FF_0000, 32'h0000_FF00,
      32'h0000_00FF, 32'h00FF_FF00, 32'h00FF_00FF, 32'h0000_FFFF, 32'h00FF_00FE,
      32'h00FF_0001, 32'h0001_0000, 32'h0000_0100, 32'h0000_0001, 32'h0001_0001,
      32'h00FE_FFFF, 32'h0080_4060, 32'h0010_2030, 32'h0030_2010, 32'h5501_0203,
      32'h00FF_FE00, 32'h0000_FEFF, 32'h0040_4041, 32'h00FF_0102};
    foreach (directed[i]) pixel_q.push_back(directed[i]);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pixel_q.size() == 0 && !s_axis_tvalid);
    run_phase(500, 0, 0);
    run_phase(450, 84, 0);
    run_phase(450, 0, 84);
    run_phase(450, 36, 36);
    recv_stall_pct = 0;
    wait (hsv_q.size() == 0);
    stim_done = 1'b1;
    repeat (10) @(posedge clk_i);
    if (errors == 0 && hsv_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
